/* hw/rtl/mwla_pkg.sv */
// Shared types, decay/gain tables and command structs for the load average block.
package mwla_pkg;

  localparam int CHANNELS = 6;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int NWIN     = 3;

  localparam logic [63:0] ONE62 = 64'd1 << 62;

  // exponent arguments in Q2.62: per-ms decay and per-second gain
  localparam logic [63:0] Y_MS_SHORT  = ONE62 / 64'd60000;
  localparam logic [63:0] Y_MS_MEDIUM = ONE62 / 64'd300000;
  localparam logic [63:0] Y_MS_LONG   = ONE62 / 64'd900000;
  localparam logic [63:0] Y_S_SHORT   = ONE62 / 64'd60;
  localparam logic [63:0] Y_S_MEDIUM  = ONE62 / 64'd300;
  localparam logic [63:0] Y_S_LONG    = ONE62 / 64'd900;

  typedef logic [31:0][31:0] ftab_t;
  typedef logic [4:0]        bit_t;

  typedef enum logic [1:0] {
    WIN_SHORT,
    WIN_MEDIUM,
    WIN_LONG
  } win_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_DELTA,
    OP_STEP,
    OP_AVG,
    OP_GAIN,
    OP_SUM,
    OP_COMMIT
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_BITS,
    ST_AVG,
    ST_GAIN,
    ST_SUM,
    ST_DONE
  } state_t;

  typedef struct packed {
    op_t  op;
    win_t win;
    bit_t bitsel;
  } dp_cmd_t;

  typedef struct packed {
    logic ch_ok;
    logic out_busy;
  } dp_sts_t;

  // floor(a * b / 2^62)
  function automatic logic [63:0] mul62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // exp(-y) in Q2.62 by alternating series
  function automatic logic [63:0] exp_neg62(input logic [63:0] y);
    logic [63:0] sum;
    logic [63:0] term;
    logic        stop;
    sum  = ONE62;
    term = ONE62;
    stop = 1'b0;
    for (int N = 1; N <= 60; N++) begin
      if (!stop) begin
        term = mul62(term, y) / N;
        if (term == 64'd0) begin
          stop = 1'b1;
        end else if (N % 2 == 1) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return sum;
  endfunction

  function automatic logic [31:0] to_q32(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << 29)) >> 30;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic ftab_t factors(input logic [63:0] y);
    ftab_t       t;
    logic [63:0] v;
    v = exp_neg62(y);
    for (int i = 0; i < 32; i++) begin
      t[i] = to_q32(v);
      v    = mul62(v, v);
    end
    return t;
  endfunction

  localparam ftab_t FACTOR_TAB [NWIN] = '{
    factors(Y_MS_SHORT), factors(Y_MS_MEDIUM), factors(Y_MS_LONG)
  };

  localparam logic [31:0] GAIN_TAB [NWIN] = '{
    to_q32(ONE62 - exp_neg62(Y_S_SHORT)),
    to_q32(ONE62 - exp_neg62(Y_S_MEDIUM)),
    to_q32(ONE62 - exp_neg62(Y_S_LONG))
  };

endpackage

/* hw/rtl/multi_window_load_average.sv */
// Top level of the six-channel 1/5/15 minute load average block.
//
// Input stream: in_tuser carries the channel, in_tdata the timestamp in ms
// and the Q16.16 amount. Each accepted word updates that channel's three
// decaying averages; a query is a word with amount zero.
// Output stream: one word per input with the three new averages.
// A channel number out of range leaves state alone and returns zeros.
// Timing: one word at a time. A valid channel runs, per window, 32 delta-bit
// decay steps, one average multiply, one gain multiply and one add, with
// every multiply through a single 33x32 multiplier, plus delta and commit
// steps; an out-of-range channel goes straight from delta to commit.
// in_tready is high only while idle, so a new word is taken only after the
// last one is committed. A result waiting in the output register does not
// block the next input; the next result waits until the receiver takes it.
// Reset (synchronous, rst_n low) zeroes all timestamps and averages and
// drops any pending result.
module multi_window_load_average import mwla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // timestamp_ms[31:0], amount[63:32]
  input  logic [2:0]  in_tuser,   // channel[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata   // avg_short[31:0], avg_medium[63:32], avg_long[95:64]
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  mwla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mwla_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_channel (in_tuser),
    .in_stamp   (in_tdata[31:0]),
    .in_amount  (in_tdata[63:32]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* hw/rtl/mwla_ctrl.sv */
// Sequencer for the load average update: walks windows and delta bits.
module mwla_ctrl import mwla_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;
  win_t   win_r, win_nxt;
  bit_t   bit_r, bit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      win_r   <= WIN_SHORT;
      bit_r   <= '0;
    end else begin
      state_r <= state_nxt;
      win_r   <= win_nxt;
      bit_r   <= bit_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    win_nxt    = win_r;
    bit_nxt    = bit_r;
    in_tready  = 1'b0;
    cmd.op     = OP_NONE;
    cmd.win    = win_r;
    cmd.bitsel = bit_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: begin
        if (sts.ch_ok) begin
          cmd.op    = OP_DELTA;
          win_nxt   = WIN_SHORT;
          bit_nxt   = '0;
          state_nxt = ST_BITS;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_BITS: begin
        cmd.op  = OP_STEP;
        bit_nxt = bit_r + 5'd1;
        if (bit_r == '1) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd.op    = OP_AVG;
        state_nxt = ST_GAIN;
      end
      ST_GAIN: begin
        cmd.op    = OP_GAIN;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.op  = OP_SUM;
        bit_nxt = '0;
        if (win_r == WIN_LONG) begin
          state_nxt = ST_DONE;
        end else begin
          win_nxt   = win_t'(win_r + 2'd1);
          state_nxt = ST_BITS;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_COMMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/mwla_datapath.sv */
// Channel state, shared multiplier, accumulate/saturate and output register.
module mwla_datapath import mwla_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  input  logic [2:0]    in_channel,
  input  logic [31:0]   in_stamp,
  input  logic [31:0]   in_amount,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [95:0]   out_tdata
);

  logic [31:0] last_stamp_r [CHANNELS];
  logic [31:0] short_avg_r  [CHANNELS];
  logic [31:0] medium_avg_r [CHANNELS];
  logic [31:0] long_avg_r   [CHANNELS];

  logic [CH_W-1:0] ch_idx_r;
  logic            ch_ok_r;
  logic [31:0]     stamp_r;
  logic [31:0]     amount_r;
  logic [31:0]     delta_r;
  logic [32:0]     p_r;
  logic [31:0]     avgp_r;
  logic [31:0]     gp_r;
  logic [31:0]     res_r [NWIN];
  logic [95:0]     out_tdata_r;
  logic            out_tvalid_r;

  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] mul_p;
  logic [31:0] avg_cur;
  logic [32:0] sum;
  logic [31:0] sat;

  always_comb begin
    unique case (cmd.win)
      WIN_SHORT:  avg_cur = short_avg_r[ch_idx_r];
      WIN_MEDIUM: avg_cur = medium_avg_r[ch_idx_r];
      WIN_LONG:   avg_cur = long_avg_r[ch_idx_r];
      default:    avg_cur = '0;
    endcase
  end

  always_comb begin
    mul_a = p_r;
    mul_b = FACTOR_TAB[cmd.win][cmd.bitsel];
    if (cmd.op == OP_AVG) begin
      mul_b = avg_cur;
    end else if (cmd.op == OP_GAIN) begin
      mul_a = {1'b0, amount_r};
      mul_b = GAIN_TAB[cmd.win];
    end
  end

  assign mul_p = 65'(mul_a) * 65'(mul_b);
  assign sum   = {1'b0, avgp_r} + {1'b0, gp_r};
  assign sat   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        ch_idx_r <= CH_W'(in_channel);
        ch_ok_r  <= (32'(in_channel) < CHANNELS);
        stamp_r  <= in_stamp;
        amount_r <= in_amount;
        for (int w = 0; w < NWIN; w++) begin
          res_r[w] <= '0;
        end
      end
      OP_DELTA: begin
        delta_r <= stamp_r - last_stamp_r[ch_idx_r];
        p_r     <= 33'd1 << 32;
      end
      OP_STEP: begin
        if (delta_r[cmd.bitsel]) begin
          p_r <= mul_p[64:32];
        end
      end
      OP_AVG: begin
        avgp_r <= mul_p[63:32];
      end
      OP_GAIN: begin
        gp_r <= mul_p[63:32];
      end
      OP_SUM: begin
        res_r[cmd.win] <= sat;
        p_r            <= 33'd1 << 32;
      end
      OP_COMMIT: begin
        out_tdata_r <= {res_r[2], res_r[1], res_r[0]};
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
        last_stamp_r[c] <= '0;
        short_avg_r[c]  <= '0;
        medium_avg_r[c] <= '0;
        long_avg_r[c]   <= '0;
      end
    end else begin
      if (cmd.op == OP_COMMIT) begin
        out_tvalid_r <= 1'b1;
        if (ch_ok_r) begin
          last_stamp_r[ch_idx_r] <= stamp_r;
          short_avg_r[ch_idx_r]  <= res_r[0];
          medium_avg_r[ch_idx_r] <= res_r[1];
          long_avg_r[ch_idx_r]   <= res_r[2];
        end
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign sts.ch_ok    = ch_ok_r;
  assign sts.out_busy = out_tvalid_r && !out_tready;
  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;

endmodule

/* tb/sv/load_avg_checker.sv */
// Checker for the load average block: tracks accepted words, predicts each result and compares it.
`timescale 1ns / 1ps
module load_avg_checker import mwla_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [63:0] in_tdata,   // timestamp_ms[31:0], amount[63:32]
  input  logic [2:0]  in_tuser,   // channel[2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [95:0] out_tdata,  // avg_short[31:0], avg_medium[63:32], avg_long[95:64]
  output int          errors,
  output int          awaiting
);

  localparam logic [63:0] Q62_ONE = 64'd1 << 62;
  localparam logic [63:0] WIN_SEC [3] = '{64'd60, 64'd300, 64'd900};

  typedef struct packed {
    logic [31:0] fifteen_min;
    logic [31:0] five_min;
    logic [31:0] one_min;
  } avg_set_t;

  logic [31:0] decay_factor [3][32];
  logic [31:0] step_gain [3];
  logic [31:0] stamp_mem [CHANNELS];
  avg_set_t    avg_mem [CHANNELS];
  avg_set_t    avg_q [$];
  int          word_no;

  function automatic logic [63:0] q62_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // alternating series for exp(-y), y in Q2.62
  function automatic logic [63:0] q62_exp_neg(input logic [63:0] y);
    logic [63:0] acc;
    logic [63:0] term;
    logic        done;
    acc  = Q62_ONE;
    term = Q62_ONE;
    done = 1'b0;
    for (logic [63:0] n = 1; n <= 60; n++) begin
      if (!done) begin
        term = q62_mul(term, y) / n;
        if (term == 64'd0) done = 1'b1;
        else if (n[0]) acc = acc - term;
        else acc = acc + term;
      end
    end
    return acc;
  endfunction

  function automatic logic [31:0] q62_to_q32(input logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << 29)) >> 30;
    return (r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : r[31:0];
  endfunction

  function automatic logic [31:0] window_update(input int w, input logic [31:0] avg,
                                                input logic [31:0] delta,
                                                input logic [31:0] amt);
    logic [63:0] keep;
    logic [63:0] total;
    keep = 64'd1 << 32;
    for (int i = 0; i < 32; i++) begin
      if (delta[i]) keep = (keep * {32'd0, decay_factor[w][i]}) >> 32;
    end
    total = (({32'd0, avg} * keep) >> 32) + (({32'd0, amt} * {32'd0, step_gain[w]}) >> 32);
    return (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    errors++;
  endtask

  initial begin : build_tables
    logic [63:0] v;
    for (int w = 0; w < 3; w++) begin
      v = q62_exp_neg(Q62_ONE / (WIN_SEC[w] * 64'd1000));
      for (int i = 0; i < 32; i++) begin
        decay_factor[w][i] = q62_to_q32(v);
        v = q62_mul(v, v);
      end
      step_gain[w] = q62_to_q32(Q62_ONE - q62_exp_neg(Q62_ONE / WIN_SEC[w]));
    end
  end

  always @(posedge clk) begin
    avg_set_t    got;
    avg_set_t    want;
    avg_set_t    upd;
    logic [31:0] delta;
    logic [31:0] stamp;
    logic [31:0] amt;
    int          ch;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        stamp_mem[c] = '0;
        avg_mem[c]   = '0;
      end
      avg_q.delete();
      errors  = 0;
      word_no = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (avg_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_tdata));
        end else begin
          want = avg_q.pop_front();
          if (got.one_min != want.one_min)
            report_mismatch($sformatf("word %0d 1 min avg %h, want %h",
                                      word_no, got.one_min, want.one_min));
          if (got.five_min != want.five_min)
            report_mismatch($sformatf("word %0d 5 min avg %h, want %h",
                                      word_no, got.five_min, want.five_min));
          if (got.fifteen_min != want.fifteen_min)
            report_mismatch($sformatf("word %0d 15 min avg %h, want %h",
                                      word_no, got.fifteen_min, want.fifteen_min));
        end
        word_no++;
      end
      if (in_tvalid && in_tready) begin
        ch    = int'(in_tuser);
        stamp = in_tdata[31:0];
        amt   = in_tdata[63:32];
        if (ch >= CHANNELS) begin
          upd = '0;
        end else begin
          delta           = stamp - stamp_mem[ch];
          stamp_mem[ch]   = stamp;
          upd.one_min     = window_update(0, avg_mem[ch].one_min, delta, amt);
          upd.five_min    = window_update(1, avg_mem[ch].five_min, delta, amt);
          upd.fifteen_min = window_update(2, avg_mem[ch].fifteen_min, delta, amt);
          avg_mem[ch]     = upd;
        end
        avg_q.push_back(upd);
      end
    end
    awaiting <= avg_q.size();
  end

endmodule

/* tb/sv/tb.sv */
// Top of the load average testbench: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb;

  localparam logic [2:0] CH_CMDS     = 3'd0;
  localparam logic [2:0] CH_COMPILE  = 3'd1;
  localparam logic [2:0] CH_ALARM    = 3'd2;
  localparam logic [2:0] CH_UDP      = 3'd3;
  localparam logic [2:0] CH_TCP      = 3'd4;
  localparam logic [2:0] CH_RUNQUEUE = 3'd5;
  localparam logic [2:0] CH_BAD_LO   = 3'd6;
  localparam logic [2:0] CH_BAD_HI   = 3'd7;

  localparam logic [31:0] AMT_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] AMT_ONE = 32'h0001_0000;

  localparam int RANDOM_ITEMS = 580;
  localparam int FLOOD_ITEMS  = 350;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES  = 1500;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic [63:0] in_tdata   = '0;   // timestamp_ms[31:0], amount[63:32]
  logic [2:0]  in_tuser   = '0;   // channel[2:0]
  logic        out_tready = 1'b0;
  logic        in_tready;
  logic        out_tvalid;
  logic [95:0] out_tdata;         // avg_short[31:0], avg_medium[63:32], avg_long[95:64]
  int          errors;
  int          awaiting;
  int          burst_left;
  logic [31:0] clock_ms;

  always #6 clk = ~clk;

  multi_window_load_average uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  load_avg_checker avg_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .errors     (errors),
    .awaiting   (awaiting)
  );

  task automatic send_word(input logic [2:0] ch, input logic [31:0] stamp,
                           input logic [31:0] amt);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= ch;
    in_tdata  <= {amt, stamp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      in_tuser  <= 3'($urandom);
      in_tdata  <= {$urandom, $urandom};
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    end
  endtask

  // receiver: segments of differing stall patterns, plus two long hold-offs
  initial begin : receiver
    int cyc;
    int mode;
    cyc  = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 3000 || cyc == 90000) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end
      if (cyc % 400 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 7) == 0);
        default: out_tready <= (cyc % 7 < 3);
      endcase
    end
  end

  initial begin : stimulus
    int          pick;
    logic [2:0]  ch;
    logic [31:0] stamp;
    logic [31:0] amt;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(CH_CMDS, 32'd0, 32'd0);               // query, no elapsed time
    send_word(CH_CMDS, 32'd0, AMT_MAX);
    send_word(CH_CMDS, 32'd1, AMT_MAX);
    send_word(CH_CMDS, 32'd60000, 32'd0);
    send_word(CH_COMPILE, 32'hFFFF_FFFF, AMT_ONE);  // every delta bit set
    send_word(CH_COMPILE, 32'd0, AMT_MAX);          // wraps to delta 1
    send_word(CH_COMPILE, 32'd5, 32'd1);
    send_word(CH_COMPILE, 32'd3, 32'h8000_0000);    // time going backwards
    send_word(CH_ALARM, 32'h8000_0000, AMT_MAX);
    send_word(CH_ALARM, 32'h8000_0000, AMT_MAX);
    send_word(CH_ALARM, 32'hAAAA_AAAA, 32'h5555_5555);
    send_word(CH_UDP, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(CH_UDP, 32'h5555_5556, 32'hFFFF_0000);
    send_word(CH_TCP, 32'd1000, 32'h0000_FFFF);
    send_word(CH_TCP, 32'd1000, 32'h0000_FFFF);
    send_word(CH_RUNQUEUE, 32'd123456, AMT_MAX);
    send_word(CH_BAD_LO, 32'hFFFF_FFFF, AMT_MAX);   // out of range, state untouched
    send_word(CH_BAD_HI, 32'd0, AMT_MAX);
    send_word(CH_RUNQUEUE, 32'd123456, 32'd0);
    send_word(CH_CMDS, 32'd60001, 32'd0);

    // event timeline starting near the wrap point
    clock_ms = 32'hFFFC_0000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < 6) ch = 3'($urandom_range(CH_BAD_LO, CH_BAD_HI));
      else ch = 3'($urandom_range(CH_CMDS, CH_RUNQUEUE));
      pick = $urandom_range(0, 99);
      if (pick < 70) clock_ms += $urandom_range(0, 4000);
      else if (pick < 80) clock_ms += $urandom_range(60000, 2000000);
      pick = $urandom_range(0, 99);
      if (pick < 8) stamp = $urandom;
      else if (pick < 14) stamp = clock_ms - $urandom_range(1, 5000);
      else stamp = clock_ms;
      pick = $urandom_range(0, 99);
      if (pick < 20) amt = 32'd0;
      else if (pick < 55) amt = $urandom_range(0, 32'h0010_0000);
      else if (pick < 80) amt = $urandom;
      else amt = AMT_MAX - $urandom_range(0, 255);
      send_word(ch, stamp, amt);
    end

    // busy channel with no elapsed time: drives the 1 and 5 min averages into saturation
    for (int n = 0; n < FLOOD_ITEMS; n++) begin
      send_word(CH_RUNQUEUE, clock_ms, (n % 100 == 99) ? 32'd0 : AMT_MAX);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS multi_window_load_average");
    end else begin
      $display("FAIL multi_window_load_average");
    end
    $finish;
  end

  initial begin : watchdog
    #30_000_000;
    $display("FAIL multi_window_load_average");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mwla_pkg.sv
hw/rtl/mwla_ctrl.sv
hw/rtl/mwla_datapath.sv
hw/rtl/multi_window_load_average.sv
tb/sv/load_avg_checker.sv
tb/sv/tb.sv
